>>> hw/rtl/pulse_capture_counter_extender_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the timer capture extender
// Short forms for the concurrent checks, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PULSE_CAPTURE_COUNTER_EXTENDER_DEFINES_SVH
`define PULSE_CAPTURE_COUNTER_EXTENDER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PCCE_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PCCE_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/pcce_pkg.sv
// ---------------------------------------------------------------------------
// pcce_pkg
// Types and constants shared by the timer capture extender.
// ---------------------------------------------------------------------------
package pcce_pkg;

   // Distance of the new compare match value ahead of the re-base point.
   localparam logic [31:0] MATCH_LEAD = 32'hC000_0000;

   // Configuration register indexes.
   localparam int          CSR_INDEX_WIDTH   = 8;
   localparam logic [7:0]  CSR_NS_MULTIPLIER = 8'd0;
   localparam logic [7:0]  CSR_NS_SHIFT      = 8'd1;

   localparam logic [5:0]  NS_SHIFT_RESET    = 6'd1;

   typedef struct packed {
      logic        capture_flag;
      logic        overflow_flag;
      logic        match_flag;
      logic [31:0] first_read;
      logic [31:0] before_read;
      logic [31:0] middle_read;
      logic [31:0] after_read;
      logic [31:0] captured_value;
      logic [31:0] match_value;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] extended_capture;
      logic [63:0] capture_interval;
      logic [63:0] extended_midpoint;
      logic [31:0] read_uncertainty;
      logic [31:0] entry_latency;
      logic [63:0] offset_ns;
      logic        used_second_pair;
      logic [31:0] next_match;
      logic        next_match_valid;
      logic [31:0] capture_total;
      logic [31:0] match_total;
      logic [31:0] overflow_total;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_INDEX_WIDTH-1:0] reg_index;
      logic [31:0]                wdata;
   } csr_payload_type;

   // Outcome of the sandwich read selection, all zero without a capture.
   typedef struct packed {
      logic        second;
      logic [31:0] uncertainty;
      logic [31:0] latency;
      logic [31:0] delta;
   } pair_sel_type;

endpackage

>>> hw/rtl/pcce_stream_if.sv
// ---------------------------------------------------------------------------
// pcce_stream_if
// Valid/ready channel carrying one payload per transfer.
// ---------------------------------------------------------------------------
interface pcce_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/pulse_capture_counter_extender.sv
// ---------------------------------------------------------------------------
// pulse_capture_counter_extender
// Turns one timer interrupt event into an extended 64-bit timestamp report.
// ---------------------------------------------------------------------------
// Path: each item passes the stage 0, 1 and 2 registers and then the output register.
// Throughput: one item per cycle unless rsp_bus stalls; the extension and counter
//   registers close their loop directly, and the 32x32 multiply has its own stage.
// Reset: synchronous, active high; clears the extension state, the counters and
//   all stage valid flags, and sets ns_multiplier to 0 and ns_shift to 1.
module pulse_capture_counter_extender (
   input logic                  clock,
   input logic                  reset,
   pcce_stream_if.sink          req_bus,
   pcce_stream_if.source        rsp_bus,
   pcce_stream_if.sink          csr_bus
);
   // Configuration registers. The user must write them only while the block is idle,
   // which the block itself does not enforce; the later stages read them directly.
   logic [31:0] ns_multiplier_ff;
   logic [5:0]  ns_shift_ff;

   // Stage 0: input register.
   logic                      s0_valid_ff;
   pcce_pkg::req_payload_type s0_item_ff;

   // Stage 1: extension done, midpoint delay waiting for the multiplier.
   logic                      s1_valid_ff;
   pcce_pkg::rsp_payload_type s1_result_ff, s1_result_in;
   logic [31:0]               s1_delta_ff;

   // Stage 2: product registered, rounding still to do.
   logic                      s2_valid_ff;
   pcce_pkg::rsp_payload_type s2_result_ff, s2_result_in;
   logic [63:0]               s2_prod_ff, s2_prod_in;

   // Output register.
   logic                      out_valid_ff;
   pcce_pkg::rsp_payload_type out_result_ff, out_result_in;

   logic out_en;
   logic s2_en;
   logic s1_en;
   logic s0_en;
   logic step;

   pcce_pkg::pair_sel_type sel;
   logic [63:0]            offset_ns;

   // Each stage loads when it is empty or when its contents move on, so bubbles
   // collapse and a full pipeline still advances every cycle the sink is ready.
   assign out_en = !out_valid_ff || rsp_bus.ready;
   assign s2_en  = !s2_valid_ff || out_en;
   assign s1_en  = !s1_valid_ff || s2_en;
   assign s0_en  = !s0_valid_ff || s1_en;

   assign req_bus.ready = s0_en;
   assign csr_bus.ready = 1'b1;

   // The extension state advances exactly when the stage 0 item moves on.
   assign step = s0_valid_ff && s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         ns_multiplier_ff <= '0;
         ns_shift_ff      <= pcce_pkg::NS_SHIFT_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.payload.reg_index)
            pcce_pkg::CSR_NS_MULTIPLIER: begin
               ns_multiplier_ff <= csr_bus.payload.wdata;
            end
            pcce_pkg::CSR_NS_SHIFT: begin
               ns_shift_ff <= csr_bus.payload.wdata[5:0];
            end
            default: begin
               // Writes to unknown indexes are dropped.
            end
         endcase
      end
   end

   pcce_pair_select u_pair_select (
      .item (s0_item_ff),
      .sel  (sel)
   );

   pcce_extend u_extend (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (s0_item_ff),
      .sel    (sel),
      .result (s1_result_in)
   );

   // The extended midpoint is the extended capture plus the capture-to-midpoint
   // delay; both are zero when there was no capture.
   always_comb begin
      s2_result_in                   = s1_result_ff;
      s2_result_in.extended_midpoint = s1_result_ff.extended_capture + {32'b0, s1_delta_ff};
   end

   assign s2_prod_in = 64'(s1_delta_ff) * 64'(ns_multiplier_ff);

   pcce_ns_round u_ns_round (
      .product (s2_prod_ff),
      .shift   (ns_shift_ff),
      .scaled  (offset_ns)
   );

   always_comb begin
      out_result_in           = s2_result_ff;
      out_result_in.offset_ns = offset_ns;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s0_en) begin
            s0_valid_ff <= req_bus.valid;
         end
         if (s1_en) begin
            s1_valid_ff <= s0_valid_ff;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_en) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s0_en) begin
         s0_item_ff <= req_bus.payload;
      end
      if (s1_en) begin
         s1_result_ff <= s1_result_in;
         s1_delta_ff  <= sel.delta;
      end
      if (s2_en) begin
         s2_result_ff <= s2_result_in;
         s2_prod_ff   <= s2_prod_in;
      end
      if (out_en) begin
         out_result_ff <= out_result_in;
      end
   end

   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.payload = out_result_ff;
endmodule

>>> hw/rtl/pcce_pair_select.sv
// ---------------------------------------------------------------------------
// pcce_pair_select
// Picks the tighter sandwich read pair and forms spread, midpoint delay and latency.
// ---------------------------------------------------------------------------
module pcce_pair_select (
   input  pcce_pkg::req_payload_type item,
   output pcce_pkg::pair_sel_type    sel
);
   logic [31:0] first_gap;
   logic [31:0] second_gap;
   logic        take_second;
   logic [31:0] low_read;
   logic [31:0] spread;
   logic [31:0] spread_inc;
   logic [31:0] midpoint;

   assign first_gap   = item.middle_read - item.before_read;
   assign second_gap  = item.after_read - item.middle_read;
   // On a tie the earlier pair is kept.
   assign take_second = first_gap > second_gap;
   assign low_read    = take_second ? item.middle_read : item.before_read;
   assign spread      = take_second ? second_gap : first_gap;
   assign spread_inc  = spread + 32'd1;
   assign midpoint    = low_read + (spread_inc >> 1);

   always_comb begin
      sel = '0;
      if (item.capture_flag) begin
         sel.second      = take_second;
         sel.uncertainty = spread + 32'd2;
         sel.latency     = item.first_read - item.captured_value;
         sel.delta       = midpoint - item.captured_value;
      end
   end
endmodule

>>> hw/rtl/pcce_extend.sv
// ---------------------------------------------------------------------------
// pcce_extend
// Holds the 64-bit extension state and the event counters, one item per step.
// ---------------------------------------------------------------------------
module pcce_extend (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  pcce_pkg::req_payload_type item,
   input  pcce_pkg::pair_sel_type    sel,
   output pcce_pkg::rsp_payload_type result
);
   logic [31:0] base_ff,    base_in;
   logic [63:0] high_ff,    high_in;
   logic [63:0] prev_ff,    prev_in;
   logic [31:0] cap_cnt_ff, cap_cnt_in;
   logic [31:0] mat_cnt_ff, mat_cnt_in;
   logic [31:0] ovf_cnt_ff, ovf_cnt_in;

   logic        rebase;
   logic [31:0] ref_value;
   logic [31:0] ref_diff;
   logic [63:0] high_rebased;

   // A capture takes precedence over a match as the re-base point.
   assign rebase       = item.capture_flag | item.match_flag;
   assign ref_value    = item.capture_flag ? item.captured_value : item.match_value;
   assign ref_diff     = ref_value - base_ff;
   assign high_rebased = high_ff + {32'b0, ref_diff};

   assign base_in    = rebase ? ref_value : base_ff;
   assign high_in    = rebase ? high_rebased : high_ff;
   assign prev_in    = item.capture_flag ? high_rebased : prev_ff;
   assign cap_cnt_in = cap_cnt_ff + {31'b0, item.capture_flag};
   assign mat_cnt_in = mat_cnt_ff + {31'b0, item.match_flag};
   assign ovf_cnt_in = ovf_cnt_ff + {31'b0, item.overflow_flag};

   always_comb begin
      result = '0;
      if (item.capture_flag) begin
         // The captured value is the new base, so its extension is the new high word.
         result.extended_capture = high_rebased;
         result.capture_interval = high_rebased - prev_ff;
         result.read_uncertainty = sel.uncertainty;
         result.entry_latency    = sel.latency;
         result.used_second_pair = sel.second;
      end
      if (rebase) begin
         result.next_match       = ref_value + pcce_pkg::MATCH_LEAD;
         result.next_match_valid = 1'b1;
      end
      result.capture_total  = cap_cnt_in;
      result.match_total    = mat_cnt_in;
      result.overflow_total = ovf_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= '0;
         high_ff    <= '0;
         prev_ff    <= '0;
         cap_cnt_ff <= '0;
         mat_cnt_ff <= '0;
         ovf_cnt_ff <= '0;
      end else if (step) begin
         base_ff    <= base_in;
         high_ff    <= high_in;
         prev_ff    <= prev_in;
         cap_cnt_ff <= cap_cnt_in;
         mat_cnt_ff <= mat_cnt_in;
         ovf_cnt_ff <= ovf_cnt_in;
      end
   end
endmodule

>>> hw/rtl/pcce_ns_round.sv
// ---------------------------------------------------------------------------
// pcce_ns_round
// Rounds a cycles-times-multiplier product and shifts it down to nanoseconds.
// ---------------------------------------------------------------------------
module pcce_ns_round (
   input  logic [63:0] product,
   input  logic [5:0]  shift,
   output logic [63:0] scaled
);
   logic [5:0]  shift_dec;
   logic [64:0] half;
   logic [64:0] sum;
   logic [64:0] shifted;

   // The sum keeps its carry so that the rounding stays exact before the shift.
   assign shift_dec = shift - 6'd1;
   assign half      = (shift == 6'd0) ? 65'd0 : (65'd1 << shift_dec);
   assign sum       = {1'b0, product} + half;
   assign shifted   = sum >> shift;
   assign scaled    = shifted[63:0];
endmodule

>>> hw/rtl/pcce_checker.sv
// ---------------------------------------------------------------------------
// pcce_checker
// Port-level checks on the result channel of the timer capture extender.
// ---------------------------------------------------------------------------
`include "pulse_capture_counter_extender_defines.svh"

module pcce_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input pcce_pkg::rsp_payload_type rsp_payload
);
   `PCCE_ASSERT_NEXT(a_rsp_valid_holds, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
   `PCCE_ASSERT_NEXT(a_rsp_payload_holds, rsp_valid && !rsp_ready, $stable(rsp_payload), "result changed while stalled")
   `PCCE_ASSERT_NOW(a_second_pair_rebases, rsp_valid && rsp_payload.used_second_pair, rsp_payload.next_match_valid, "second pair without re-base")
   `PCCE_ASSERT_NOW(a_idle_fields_zero, rsp_valid && !rsp_payload.next_match_valid, rsp_payload.extended_capture == 64'd0 && rsp_payload.offset_ns == 64'd0 && rsp_payload.next_match == 32'd0, "capture fields set without re-base")
   `PCCE_ASSERT_NOW(a_no_result_after_reset, $past(reset), !rsp_valid, "result valid right after reset")
endmodule

bind pulse_capture_counter_extender pcce_checker u_pcce_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_payload (rsp_bus.payload)
);

>>> tb/pulse_capture_counter_extender_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pulse_capture_counter_extender_checker
// Watches the event, result and register channels of the timer capture
// extender. It keeps its own copy of the extension state and the cycle to
// nanosecond setting, predicts one timestamp report per accepted event and
// compares every delivered report field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module pulse_capture_counter_extender_checker
   import pcce_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   input  logic            csr_ready,
   input  csr_payload_type csr_payload,
   output int              failures,
   output int              outstanding
);

   localparam int MAX_PRINTED = 40;

   // Register copies.
   logic [31:0] ns_multiplier_reg;
   logic [5:0]  ns_shift_reg;

   // Extension and counter state.
   logic [31:0] rebase_low;
   logic [63:0] rebase_extended;
   logic [63:0] last_capture;
   logic [31:0] capture_count;
   logic [31:0] match_count;
   logic [31:0] overflow_count;

   rsp_payload_type pending_reports[$];
   rsp_payload_type oldest_report;
   int              report_number;

   task automatic report_mismatch(input string msg);
      if (failures < MAX_PRINTED)
         $display("%0t ns mismatch: %s", $time, msg);
      failures++;
   endtask

   task automatic compare_field(input string name, input logic [63:0] got,
                                input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("report %0d %s: got 0x%0h, expected 0x%0h",
                                   report_number, name, got, want));
   endtask

   function automatic void rebase_extension(input logic [31:0] anchor);
      logic [31:0] advance;
      advance         = anchor - rebase_low;
      rebase_low      = anchor;
      rebase_extended = rebase_extended + 64'(advance);
   endfunction

   function automatic logic [63:0] widen_count(input logic [31:0] count);
      logic [31:0] offset;
      offset = count - rebase_low;
      return rebase_extended + 64'(offset);
   endfunction

   // Multiply, add half an output unit, then shift; the sum keeps its carry.
   function automatic logic [63:0] cycles_to_nanoseconds(input logic [31:0] cycles);
      logic [63:0] product;
      logic [64:0] rounded;
      product = 64'(cycles) * 64'(ns_multiplier_reg);
      if (ns_shift_reg == 6'd0)
         return product;
      rounded = {1'b0, product} + (65'd1 << (ns_shift_reg - 6'd1));
      rounded = rounded >> ns_shift_reg;
      return rounded[63:0];
   endfunction

   function automatic rsp_payload_type timestamp_report(input req_payload_type ev);
      rsp_payload_type rpt;
      logic [31:0]     first_gap;
      logic [31:0]     second_gap;
      logic [31:0]     low;
      logic [31:0]     spread;
      logic [31:0]     span;
      logic [31:0]     midpoint;
      rpt = '0;
      if (ev.capture_flag) begin
         first_gap  = ev.middle_read - ev.before_read;
         second_gap = ev.after_read - ev.middle_read;
         // The earlier pair wins a tie.
         if (first_gap <= second_gap) begin
            low    = ev.before_read;
            spread = first_gap;
         end else begin
            low                  = ev.middle_read;
            spread               = second_gap;
            rpt.used_second_pair = 1'b1;
         end
         span     = spread + 32'd1;
         midpoint = low + (span >> 1);

         rebase_extension(ev.captured_value);
         rpt.next_match        = ev.captured_value + MATCH_LEAD;
         rpt.next_match_valid  = 1'b1;
         rpt.extended_capture  = widen_count(ev.captured_value);
         rpt.capture_interval  = rpt.extended_capture - last_capture;
         last_capture          = rpt.extended_capture;
         rpt.extended_midpoint = widen_count(midpoint);
         rpt.read_uncertainty  = spread + 32'd2;
         rpt.entry_latency     = ev.first_read - ev.captured_value;
         rpt.offset_ns         = cycles_to_nanoseconds(midpoint - ev.captured_value);
         capture_count++;
      end
      if (ev.overflow_flag)
         overflow_count++;
      if (ev.match_flag) begin
         // A capture in the same event already re-based the extension.
         if (!ev.capture_flag) begin
            rebase_extension(ev.match_value);
            rpt.next_match       = ev.match_value + MATCH_LEAD;
            rpt.next_match_valid = 1'b1;
         end
         match_count++;
      end
      rpt.capture_total  = capture_count;
      rpt.match_total    = match_count;
      rpt.overflow_total = overflow_count;
      return rpt;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         ns_multiplier_reg = '0;
         ns_shift_reg      = NS_SHIFT_RESET;
         rebase_low        = '0;
         rebase_extended   = '0;
         last_capture      = '0;
         capture_count     = '0;
         match_count       = '0;
         overflow_count    = '0;
         report_number     = 0;
         pending_reports.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_payload.reg_index == CSR_NS_MULTIPLIER)
               ns_multiplier_reg = csr_payload.wdata;
            else if (csr_payload.reg_index == CSR_NS_SHIFT)
               ns_shift_reg = csr_payload.wdata[5:0];
         end
         if (req_valid && req_ready)
            pending_reports.push_back(timestamp_report(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (pending_reports.size() == 0) begin
               report_mismatch($sformatf("report %0d arrived with none pending",
                                         report_number));
            end else begin
               oldest_report = pending_reports.pop_front();
               compare_field("extended_capture", rsp_payload.extended_capture,
                             oldest_report.extended_capture);
               compare_field("capture_interval", rsp_payload.capture_interval,
                             oldest_report.capture_interval);
               compare_field("extended_midpoint", rsp_payload.extended_midpoint,
                             oldest_report.extended_midpoint);
               compare_field("read_uncertainty", 64'(rsp_payload.read_uncertainty),
                             64'(oldest_report.read_uncertainty));
               compare_field("entry_latency", 64'(rsp_payload.entry_latency),
                             64'(oldest_report.entry_latency));
               compare_field("offset_ns", rsp_payload.offset_ns, oldest_report.offset_ns);
               compare_field("used_second_pair", 64'(rsp_payload.used_second_pair),
                             64'(oldest_report.used_second_pair));
               compare_field("next_match", 64'(rsp_payload.next_match),
                             64'(oldest_report.next_match));
               compare_field("next_match_valid", 64'(rsp_payload.next_match_valid),
                             64'(oldest_report.next_match_valid));
               compare_field("capture_total", 64'(rsp_payload.capture_total),
                             64'(oldest_report.capture_total));
               compare_field("match_total", 64'(rsp_payload.match_total),
                             64'(oldest_report.match_total));
               compare_field("overflow_total", 64'(rsp_payload.overflow_total),
                             64'(oldest_report.overflow_total));
            end
            report_number++;
         end
      end
      outstanding = pending_reports.size();
   end

endmodule

>>> tb/pulse_capture_counter_extender_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pulse_capture_counter_extender_tb
// Drives timer interrupt events and register writes into the capture
// extender and leaves prediction and comparison to the checker beside it.
// A short directed run covers the corner cases, then random phases under
// several cycle to nanosecond settings exercise the extension over time.
// ---------------------------------------------------------------------------
module pulse_capture_counter_extender_tb;
   import pcce_pkg::*;

   localparam int          RANDOM_PHASES   = 6;
   localparam int          ITEMS_PER_PHASE = 155;
   localparam int          HOLD_OFF_CYCLES = 64;
   localparam int          DRAIN_CYCLES    = 10;
   localparam longint      LIMIT_NS        = 5_000_000;
   // An index that maps to no register; a write to it must change nothing.
   localparam logic [7:0]  CSR_UNMAPPED    = 8'hFF;

   typedef enum logic [1:0] {
      ALWAYS_READY,
      COIN_FLIP,
      MOSTLY_STALLED,
      SPARSE_PATTERN
   } stall_mode_type;

   logic clock = 1'b0;
   logic reset;
   int   failures;
   int   outstanding;

   // Sender burst bookkeeping and the long hold-off handshake between the
   // stimulus process and the receiver process.
   int          burst_left        = 0;
   int          hold_off_requests = 0;
   int          hold_off_served   = 0;
   // Free-running count that the well-formed events are built around.
   logic [31:0] timeline          = '0;

   pcce_stream_if #(.payload_type(req_payload_type)) req_bus ();
   pcce_stream_if #(.payload_type(rsp_payload_type)) rsp_bus ();
   pcce_stream_if #(.payload_type(csr_payload_type)) csr_bus ();

   pulse_capture_counter_extender u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   pulse_capture_counter_extender_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_ready   (req_bus.ready),
      .req_payload (req_bus.payload),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .rsp_payload (rsp_bus.payload),
      .csr_valid   (csr_bus.valid),
      .csr_ready   (csr_bus.ready),
      .csr_payload (csr_bus.payload),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   // Offers one event, opening a new burst after a random gap when the
   // current burst is used up. Valid stays high between items of a burst.
   task automatic offer_event(input req_payload_type ev);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(9) < 4) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_bus.payload <= ev;
      req_bus.valid   <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      burst_left--;
   endtask

   // One register transfer; valid is left high so that writes can follow
   // back to back, and the caller lowers it.
   task automatic write_register(input logic [7:0] index, input logic [31:0] value);
      csr_payload_type wr;
      wr.reg_index = index;
      wr.wdata     = value;
      csr_bus.payload <= wr;
      csr_bus.valid   <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
   endtask

   task automatic set_ns_conversion(input logic [31:0] multiplier, input logic [5:0] shift);
      write_register(CSR_NS_MULTIPLIER, multiplier);
      write_register(CSR_NS_SHIFT, {26'd0, shift});
      csr_bus.valid <= 1'b0;
   endtask

   // Stops offering and waits until every predicted report has come back,
   // so that the registers can be rewritten while the block is idle.
   task automatic wait_until_drained();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (outstanding != 0) @(negedge clock);
   endtask

   function automatic req_payload_type make_event(
      input logic cap, input logic ovf, input logic mat,
      input logic [31:0] first, input logic [31:0] prior, input logic [31:0] middle,
      input logic [31:0] after, input logic [31:0] captured, input logic [31:0] matchv);
      req_payload_type ev;
      ev.capture_flag   = cap;
      ev.overflow_flag  = ovf;
      ev.match_flag     = mat;
      ev.first_read     = first;
      ev.before_read    = prior;
      ev.middle_read    = middle;
      ev.after_read     = after;
      ev.captured_value = captured;
      ev.match_value    = matchv;
      return ev;
   endfunction

   // Most events look like a real interrupt: the reads follow the capture
   // in order with small spacing along a running count that sometimes jumps
   // by more than half the counter range. The rest is unstructured noise.
   function automatic req_payload_type random_event();
      req_payload_type ev;
      int              kind;
      ev = '0;
      if ($urandom_range(99) < 25) begin
         ev.capture_flag   = 1'($urandom_range(1));
         ev.overflow_flag  = 1'($urandom_range(1));
         ev.match_flag     = 1'($urandom_range(1));
         ev.first_read     = $urandom;
         ev.before_read    = $urandom;
         ev.middle_read    = $urandom;
         ev.after_read     = $urandom;
         ev.captured_value = $urandom;
         ev.match_value    = $urandom;
      end else begin
         if ($urandom_range(3) == 0)
            timeline = timeline + $urandom;
         else
            timeline = timeline + $urandom_range(1, 1 << 20);
         kind = $urandom_range(9);
         case (kind)
            5, 6: ev.match_flag = 1'b1;
            7: ev.overflow_flag = 1'b1;
            8: begin
               ev.capture_flag  = 1'b1;
               ev.overflow_flag = 1'($urandom_range(1));
               ev.match_flag    = ~ev.overflow_flag;
            end
            9: begin
               ev.capture_flag  = 1'($urandom_range(1));
               ev.overflow_flag = 1'($urandom_range(1));
               ev.match_flag    = 1'($urandom_range(1));
            end
            default: ev.capture_flag = 1'b1;
         endcase
         ev.captured_value = timeline;
         ev.first_read     = ev.captured_value + $urandom_range(2000);
         ev.before_read    = ev.first_read + $urandom_range(200);
         ev.middle_read    = ev.before_read + $urandom_range(1, 60);
         ev.after_read     = ev.middle_read + $urandom_range(1, 60);
         ev.match_value    = timeline + $urandom_range(50);
      end
      return ev;
   endfunction

   // Receiver: the ready pattern switches between randomly chosen modes, and a
   // long hold-off is served whenever the stimulus asks for one, so that the
   // pipeline fills and pushes back on the event channel.
   initial begin : receiver
      stall_mode_type mode;
      int             mode_cycles;
      int             pattern_step;
      mode         = ALWAYS_READY;
      mode_cycles  = 0;
      pattern_step = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_served < hold_off_requests) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_served++;
         end else begin
            if (mode_cycles == 0) begin
               mode        = stall_mode_type'($urandom_range(3));
               mode_cycles = $urandom_range(20, 200);
            end
            mode_cycles--;
            pattern_step++;
            case (mode)
               ALWAYS_READY:   rsp_bus.ready <= 1'b1;
               COIN_FLIP:      rsp_bus.ready <= 1'($urandom_range(1));
               MOSTLY_STALLED: rsp_bus.ready <= ($urandom_range(3) == 0);
               SPARSE_PATTERN: rsp_bus.ready <= ((pattern_step % 5) < 2);
               default:        rsp_bus.ready <= 1'b1;
            endcase
         end
      end
   end

   // Safety net against a hung handshake or a lost report.
   initial begin : watchdog
      #(LIMIT_NS);
      $display("FAILED: results differ");
      $finish;
   end

   initial begin : stimulus
      reset = 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.payload <= '0;
      csr_bus.valid   <= 1'b0;
      csr_bus.payload <= '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset setting: multiplier zero, shift one. An idle event and an
      // all-zero capture, which is a tie between the two read pairs.
      offer_event(make_event(0, 0, 0, '0, '0, '0, '0, '0, '0));
      offer_event(make_event(1, 0, 0, '0, '0, '0, '0, '0, '0));
      wait_until_drained();

      // A write to an unmapped index first; it must leave both registers alone.
      write_register(CSR_UNMAPPED, 32'hFFFF_FFFF);
      set_ns_conversion(32'hFFFF_FFFF, 6'd32);

      // Every read at full scale.
      offer_event(make_event(1, 0, 0, '1, '1, '1, '1, '1, '1));
      // Equal spreads keep the earlier pair.
      offer_event(make_event(1, 0, 0, 32'd90, 32'd100, 32'd110, 32'd120, 32'd50, 32'd0));
      // The later pair is tighter.
      offer_event(make_event(1, 0, 0, 32'd5, 32'd0, 32'd1000, 32'd1001, 32'd0, 32'd0));
      // Reads that straddle the counter wrap.
      offer_event(make_event(1, 0, 0, 32'hFFFF_FFE0, 32'hFFFF_FFF0, 32'h0000_0010,
                             32'h0000_0050, 32'hFFFF_FF00, 32'd0));
      // Largest spread: spread plus one wraps to zero and the midpoint is the
      // low read, while the uncertainty wraps to one.
      offer_event(make_event(1, 0, 0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                             32'h8000_0000, 32'd0));
      // Match events alone re-base the extension, forward and then backward.
      offer_event(make_event(0, 0, 1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h8000_0000));
      offer_event(make_event(0, 0, 1, '1, '1, '1, '1, '1, 32'd0));
      // Overflow alone only counts.
      offer_event(make_event(0, 1, 0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
      // Capture and match together: the capture re-bases, the match still counts.
      offer_event(make_event(1, 0, 1, 32'h4000_0100, 32'h4000_0200, 32'h4000_0210,
                             32'h4000_0230, 32'h4000_0000, 32'hFFFF_FFFF));
      // All three flags at once.
      offer_event(make_event(1, 1, 1, 32'h5000_0010, 32'h5000_0020, 32'h5000_0030,
                             32'h5000_0031, 32'h5000_0000, 32'h1234_5678));
      // A capture behind the previous one.
      offer_event(make_event(1, 0, 0, 32'd1100, 32'd1200, 32'd1201, 32'd1300,
                             32'd1000, 32'd0));
      // No flags with every field at full scale changes nothing but the report.
      offer_event(make_event(0, 0, 0, '1, '1, '1, '1, '1, '1));
      wait_until_drained();

      // Shift of zero: no rounding term and no shift.
      set_ns_conversion(32'hFFFF_FFFF, 6'd0);
      offer_event(make_event(1, 0, 0, 32'd0, 32'd0, 32'd2, 32'd100, 32'd0, 32'd0));
      offer_event(make_event(1, 0, 0, 32'd0, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'd0, 32'd0));
      wait_until_drained();

      // Largest shift: the rounded product carries out of 64 bits.
      set_ns_conversion(32'hFFFF_FFFF, 6'd63);
      offer_event(make_event(1, 0, 0, 32'd0, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'd0, 32'd0));
      offer_event(make_event(1, 0, 0, 32'd10, 32'd20, 32'd22, 32'd40, 32'd0, 32'd0));
      wait_until_drained();

      // Just above the nominal shift range.
      set_ns_conversion(32'hFFFF_FFFF, 6'd33);
      offer_event(make_event(1, 0, 0, 32'd0, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'd0, 32'd0));
      wait_until_drained();

      // Smallest nonzero multiplier with the smallest shift: a half rounds up.
      set_ns_conversion(32'd1, 6'd1);
      offer_event(make_event(1, 0, 0, 32'd0, 32'd0, 32'd2, 32'd100, 32'd0, 32'd0));

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_until_drained();
         case (phase)
            0: set_ns_conversion($urandom, 6'($urandom_range(1, 32)));
            1: set_ns_conversion(32'hFFFF_FFFF, 6'd1);
            2: set_ns_conversion(32'd0, 6'd32);
            3: set_ns_conversion($urandom, 6'd0);
            4: set_ns_conversion($urandom, 6'd63);
            default: set_ns_conversion($urandom, 6'($urandom_range(63)));
         endcase
         // In two phases the receiver stalls for a long stretch while events
         // keep coming, so the block has to hold off its input.
         if (phase == 1 || phase == 4)
            hold_off_requests++;
         repeat (ITEMS_PER_PHASE) offer_event(random_event());
      end

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
